// File: hdl/mhf_pkg.sv
// mhf_pkg: shared widths, constants and CRC helper for the MAC hash filter builder.
// No dependencies; compiled first.
package mhf_pkg;

  localparam int ADDR_BYTES = 6;
  localparam int ADDR_W     = 8 * ADDR_BYTES;
  localparam int CRC_W      = 32;
  localparam int IDX_W      = 6;
  localparam int TABLE_W    = 1 << IDX_W;
  localparam int IDX_LSB    = 26;

  localparam logic [CRC_W-1:0] CRC_PRESET = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB8_8320;

  // func codes
  localparam logic FUNC_CLEAR = 1'b0;
  localparam logic FUNC_ADD   = 1'b1;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [TABLE_W-1:0] table_t;
  typedef logic [CRC_W-1:0]   crc_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  // one byte of reflected CRC-32, LSB first
  function automatic crc_t crc_byte(input crc_t c_in, input logic [7:0] d);
    crc_t c;
    c = c_in ^ {24'd0, d};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/mhf_if.sv
// Channel interfaces for the MAC hash filter builder: address items in, table results out.
// Depends on mhf_pkg.
interface mhf_in_if;
  logic                 valid;
  logic                 ready;
  logic                 func;
  mhf_pkg::addr_t       mac_address;
  logic                 entry_valid;

  modport source (output valid, func, mac_address, entry_valid, input ready);
  modport sink   (input valid, func, mac_address, entry_valid, output ready);
endinterface

interface mhf_out_if;
  logic                 valid;
  logic                 ready;
  mhf_pkg::idx_t        hash_index;
  logic                 is_multicast;
  mhf_pkg::table_t      unicast_table;
  mhf_pkg::table_t      multicast_table;

  modport source (output valid, hash_index, is_multicast, unicast_table, multicast_table,
                  input ready);
  modport sink   (input valid, hash_index, is_multicast, unicast_table, multicast_table,
                  output ready);
endinterface

// File: hdl/mhf_crc.sv
// mhf_crc: combinational reflected CRC-32 over the six address bytes, first byte first,
// as a chain of byte steps. Depends on mhf_pkg.
module mhf_crc (
  input  mhf_pkg::addr_t addr,
  output mhf_pkg::crc_t  crc
);
  import mhf_pkg::*;

  crc_t chain [ADDR_BYTES+1];

  assign chain[0] = CRC_PRESET;

  for (genvar i = 0; i < ADDR_BYTES; i++) begin : g_byte
    assign chain[i+1] = crc_byte(chain[i], addr[ADDR_W-1-8*i -: 8]);
  end

  assign crc = chain[ADDR_BYTES];

endmodule

// File: hdl/mac_hash_filter_builder.sv
// Receive address hash table builder: one input register stage, CRC and table update,
// one result register. Depends on mhf_pkg, mhf_if.sv and mhf_crc.
//
// Each transfer on in_chan yields exactly one transfer on out_chan. A clear item zeroes
// both 64-bit tables; a valid add item hashes the 48-bit address (reflected CRC-32,
// bits 31..26) and sets that bit in the multicast table when the group bit of the first
// byte is set, else in the unicast table. Results show the tables after the item. One
// item per cycle is taken in steady state while out_chan.ready is high; result valid
// follows an input transfer through the input register, then the result register.
// in_chan.ready follows out_chan.ready combinationally through the two-stage pipeline.
module mac_hash_filter_builder (
  input  logic       clk,
  input  logic       rst_n,
  mhf_in_if.sink     in_chan,
  mhf_out_if.source  out_chan
);
  import mhf_pkg::*;

  // input stage
  logic  s1_valid_r;
  logic  s1_func_r;
  addr_t s1_addr_r;
  logic  s1_entry_r;

  // result stage
  logic   out_valid_r;
  idx_t   out_idx_r,  out_idx_nxt;
  logic   out_mc_r,   out_mc_nxt;

  // tables
  table_t uc_r, uc_nxt;
  table_t mc_r, mc_nxt;

  crc_t   crc;
  logic   s1_adv;
  logic   is_add;
  logic   group;
  idx_t   idx;

  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;

  mhf_crc u_crc (
    .addr (s1_addr_r),
    .crc  (crc)
  );

  assign idx    = crc[IDX_LSB +: IDX_W];
  assign group  = s1_addr_r[ADDR_W-8];
  assign is_add = (s1_func_r == FUNC_ADD) && s1_entry_r;

  always_comb begin
    uc_nxt      = uc_r;
    mc_nxt      = mc_r;
    out_idx_nxt = '0;
    out_mc_nxt  = 1'b0;
    if (s1_func_r == FUNC_CLEAR) begin
      uc_nxt = '0;
      mc_nxt = '0;
    end else if (is_add) begin
      out_idx_nxt = idx;
      out_mc_nxt  = group;
      if (group) begin
        mc_nxt = mc_r | (table_t'(1) << idx);
      end else begin
        uc_nxt = uc_r | (table_t'(1) << idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      uc_r        <= '0;
      mc_r        <= '0;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        uc_r        <= uc_nxt;
        mc_r        <= mc_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_func_r  <= in_chan.func;
      s1_addr_r  <= in_chan.mac_address;
      s1_entry_r <= in_chan.entry_valid;
    end
    if (s1_adv) begin
      out_idx_r <= out_idx_nxt;
      out_mc_r  <= out_mc_nxt;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.hash_index      = out_idx_r;
  assign out_chan.is_multicast    = out_mc_r;
  assign out_chan.unicast_table   = uc_r;
  assign out_chan.multicast_table = mc_r;

endmodule

// File: hdl/mhf_checker.sv
// mhf_checker: port-level assertions for mac_hash_filter_builder, bound to the top level.
// Depends on mhf_pkg.
module mhf_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input mhf_pkg::idx_t   hash_index,
  input logic            is_multicast,
  input mhf_pkg::table_t unicast_table,
  input mhf_pkg::table_t multicast_table
);
  import mhf_pkg::*;

  logic out_xfer;
  assign out_xfer = out_valid && out_ready;

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(unicast_table)
      && $stable(multicast_table) && $stable(hash_index))
    else $error("result changed while stalled");

  // a multicast add shows its bit in the multicast table
  a_mc_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_multicast |-> multicast_table[hash_index])
    else $error("multicast bit missing");

  // tables only grow between back-to-back transfers, except a clear
  a_grow: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer ##1 out_xfer |->
      ((unicast_table == '0) && (multicast_table == '0)) ||
      (((unicast_table & $past(unicast_table)) == $past(unicast_table)) &&
       ((multicast_table & $past(multicast_table)) == $past(multicast_table))))
    else $error("table bit lost without clear");

  // nothing valid right after reset
  a_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind mac_hash_filter_builder mhf_checker u_mhf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .hash_index      (out_chan.hash_index),
  .is_multicast    (out_chan.is_multicast),
  .unicast_table   (out_chan.unicast_table),
  .multicast_table (out_chan.multicast_table)
);
